>>> sv/ucfr_pkg.sv
package ucfr_pkg;

    // Reset values of the frame delimiters
    localparam logic [7:0] START_BYTE_DEFAULT = 8'hAA;
    localparam logic [7:0] END_BYTE_DEFAULT   = 8'h55;

    // Command and argument codes
    localparam logic [7:0] CMD_LED  = 8'h01;
    localparam logic [7:0] ARG_LED0 = 8'h01;
    localparam logic [7:0] ARG_LED1 = 8'h02;
    localparam logic [7:0] LED_ON   = 8'h01;

    // Configuration register indexes
    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_END_BYTE   = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_CMD,
        PH_DATA,
        PH_CHK,
        PH_END
    } ucfr_phase_t;

    typedef struct packed {
        logic led_zero;
        logic led_one;
        logic frame_accepted;
        logic frame_dropped;
    } ucfr_result_t;

endpackage

>>> sv/ucfr_if.sv
interface ucfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ucfr_result_if;
    logic valid;
    logic ready;
    logic led_zero;
    logic led_one;
    logic frame_accepted;
    logic frame_dropped;

    modport source (
        output valid, output led_zero, output led_one,
        output frame_accepted, output frame_dropped, input ready
    );
    modport sink (
        input valid, input led_zero, input led_one,
        input frame_accepted, input frame_dropped, output ready
    );
endinterface

>>> sv/ucfr_parser.sv
module ucfr_parser #(
    parameter int MAX_FRAME = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            start_byte,
    input  logic [7:0]            end_byte,
    output ucfr_pkg::ucfr_result_t result
);
    import ucfr_pkg::*;

    localparam int LEN_W = $clog2(MAX_FRAME);

    ucfr_phase_t      phase_reg, phase_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       arg1_reg, arg1_next;
    logic [7:0]       arg2_reg, arg2_next;
    logic [1:0]       led_reg, led_next;
    logic             accepted;
    logic             dropped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            length_reg <= '0;
            xor_reg    <= '0;
            cmd_reg    <= '0;
            arg1_reg   <= '0;
            arg2_reg   <= '0;
            led_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            xor_reg    <= xor_next;
            cmd_reg    <= cmd_next;
            arg1_reg   <= arg1_next;
            arg2_reg   <= arg2_next;
            led_reg    <= led_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        xor_next    = xor_reg;
        cmd_next    = cmd_reg;
        arg1_next   = arg1_reg;
        arg2_next   = arg2_reg;
        led_next    = led_reg;
        accepted    = 1'b0;
        dropped     = 1'b0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == start_byte)
                begin
                    phase_next = PH_LEN;
                    count_next = '0;
                    xor_next   = '0;
                end
            end
            PH_LEN:
            begin
                if ({1'b0, rx_byte} >= 9'(MAX_FRAME))
                begin
                    phase_next = PH_HUNT;
                    dropped    = 1'b1;
                end
                else
                begin
                    length_next = rx_byte[LEN_W-1:0];
                    phase_next  = PH_CMD;
                end
            end
            PH_CMD:
            begin
                cmd_next   = rx_byte;
                count_next = LEN_W'(1);
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (count_reg == LEN_W'(1))
                    arg1_next = rx_byte;
                else if (count_reg == LEN_W'(2))
                    arg2_next = rx_byte;
                count_next = count_reg + LEN_W'(1);
                xor_next   = xor_reg ^ rx_byte;
                // always take at least one data byte, then stop at the length
                if (count_next >= length_reg)
                    phase_next = PH_CHK;
            end
            PH_CHK:
            begin
                if (rx_byte == xor_reg)
                    phase_next = PH_END;
                else
                begin
                    phase_next = PH_HUNT;
                    dropped    = 1'b1;
                end
            end
            PH_END:
            begin
                // ignore stray bytes until the end byte
                if (rx_byte == end_byte)
                begin
                    phase_next = PH_HUNT;
                    accepted   = 1'b1;
                    if (cmd_reg == CMD_LED)
                    begin
                        if (arg1_reg == ARG_LED0)
                            led_next[0] = (arg2_reg == LED_ON);
                        else if (arg1_reg == ARG_LED1)
                            led_next[1] = (arg2_reg == LED_ON);
                    end
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    assign result.led_zero       = led_next[0];
    assign result.led_one        = led_next[1];
    assign result.frame_accepted = accepted;
    assign result.frame_dropped  = dropped;

endmodule

>>> sv/uart_command_frame_receiver.sv
// Command frame receiver for a byte-serial link.
// rx_ch carries one received byte per transaction; res_ch returns exactly one
// result per byte: the LED drive after that byte and pulses for a frame that
// closed with a good check or was dropped (length too large, bad check).
// Frame: start byte, length, command, data bytes, XOR check byte, end byte.
// Start and end bytes are set through the write port (cfg_we, cfg_index,
// cfg_wdata) and should only change while no byte is in flight.
// A result passes through the input register, then the parse and result
// register, before res_ch can take it. Throughput: one byte per cycle while
// res_ch does not stall; the parser is a single state update between those
// registers.
// If res_ch stalls, the result register holds and the input register still
// takes one more byte; rx_ch.ready drops once both are full and returns
// in the cycle the result is taken.
// Reset clears the parser to hunting for the start byte, turns both LEDs
// off, empties both registers and restores start 0xAA and end 0x55.
module uart_command_frame_receiver #(
    parameter int MAX_FRAME = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_wdata,
    ucfr_byte_if.sink         rx_ch,
    ucfr_result_if.source     res_ch
);
    import ucfr_pkg::*;

    logic         s1_valid_reg, s1_valid_next;
    logic [7:0]   s1_byte_reg;
    logic         out_valid_reg, out_valid_next;
    ucfr_result_t out_result_reg;
    ucfr_result_t parse_result;
    logic [7:0]   start_byte_reg;
    logic [7:0]   end_byte_reg;
    logic         out_free;
    logic         s2_fire;
    logic         rx_fire;

    assign out_free    = !out_valid_reg || res_ch.ready;
    assign s2_fire     = s1_valid_reg && out_free;
    assign rx_ch.ready = !s1_valid_reg || out_free;
    assign rx_fire     = rx_ch.valid && rx_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rx_fire)
            s1_valid_next = 1'b1;
        else if (s2_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_fire)
            out_valid_next = 1'b1;
        else if (res_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            start_byte_reg <= START_BYTE_DEFAULT;
            end_byte_reg   <= END_BYTE_DEFAULT;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_START_BYTE: start_byte_reg <= cfg_wdata;
                    CFG_END_BYTE:   end_byte_reg   <= cfg_wdata;
                    default:        start_byte_reg <= start_byte_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
            s1_byte_reg <= rx_ch.rx_byte;
        if (s2_fire)
            out_result_reg <= parse_result;
    end

    ucfr_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s2_fire),
        .rx_byte    (s1_byte_reg),
        .start_byte (start_byte_reg),
        .end_byte   (end_byte_reg),
        .result     (parse_result)
    );

    assign res_ch.valid          = out_valid_reg;
    assign res_ch.led_zero       = out_result_reg.led_zero;
    assign res_ch.led_one        = out_result_reg.led_one;
    assign res_ch.frame_accepted = out_result_reg.frame_accepted;
    assign res_ch.frame_dropped  = out_result_reg.frame_dropped;

endmodule

>>> sv/ucfr_checker.sv
module ucfr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic led_zero,
    input logic led_one,
    input logic frame_accepted,
    input logic frame_dropped
);
    logic [1:0] pending_reg, pending_next;
    logic [1:0] led_seen_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && !out_fire)
            pending_next = pending_reg + 2'd1;
        else if (!in_fire && out_fire)
            pending_next = pending_reg - 2'd1;
    end

    // track bytes in flight and the LED drive last delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            led_seen_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_fire)
                led_seen_reg <= {led_one, led_zero};
        end
    end

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result shown with no byte in flight");

    a_two_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two bytes in flight");

    a_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_accepted && frame_dropped))
        else $error("frame accepted and dropped in one result");

    a_led_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ({led_one, led_zero} != led_seen_reg) |-> frame_accepted)
        else $error("LED drive changed without an accepted frame");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({led_zero, led_one, frame_accepted, frame_dropped}))
        else $error("stalled result changed");

endmodule

bind uart_command_frame_receiver ucfr_checker u_ucfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (rx_ch.valid),
    .in_ready       (rx_ch.ready),
    .out_valid      (res_ch.valid),
    .out_ready      (res_ch.ready),
    .led_zero       (res_ch.led_zero),
    .led_one        (res_ch.led_one),
    .frame_accepted (res_ch.frame_accepted),
    .frame_dropped  (res_ch.frame_dropped)
);
